FILE: rtl/blpt_pkg.sv
package blpt_pkg;

   localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_LF         = 8'h0a;
   localparam logic [7:0] CHAR_CR         = 8'h0d;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_LOWER_S    = 8'h73;
   localparam logic [7:0] CHAR_LOWER_T    = 8'h74;
   localparam logic [7:0] CHAR_LOWER_M    = 8'h6d;
   localparam logic [7:0] CHAR_LOWER_D    = 8'h64;
   localparam logic [7:0] CHAR_LOWER_R    = 8'h72;
   localparam logic [7:0] CHAR_LOWER_V    = 8'h76;
   localparam logic [7:0] CHAR_LOWER_L    = 8'h6c;
   localparam logic [7:0] CHAR_LOWER_E    = 8'h65;
   localparam logic [7:0] HIGH_BYTE_FIRST = 8'h80;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_LETTER = 3'd1,
      KIND_DIGIT  = 3'd2,
      KIND_SPACE  = 3'd3,
      KIND_OTHER  = 3'd4,
      KIND_CONTR  = 3'd5
   } piece_kind_type;

   // open piece and remaining contraction bytes
   typedef struct packed {
      piece_kind_type kind;
      logic [1:0]     contr_left;
   } piece_state_type;

   // byte under decision plus up to two bytes of context
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] n;
   } window_type;

   function automatic logic byte_is_alpha(input logic [7:0] b);
      return (b inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || (b >= HIGH_BYTE_FIRST);
   endfunction

   function automatic logic byte_is_num(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

   function automatic logic byte_is_blank(input logic [7:0] b);
      return b inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR};
   endfunction

endpackage

FILE: rtl/blpt_if.sv
interface blpt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface blpt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] piece_byte;
   logic       starts_piece;
   logic       ends_text;
   logic       last_of_run;

   modport source (output valid, output piece_byte, output starts_piece,
                   output ends_text, output last_of_run, input ready);
   modport sink   (input valid, input piece_byte, input starts_piece,
                   input ends_text, input last_of_run, output ready);
endinterface

FILE: rtl/blpt_decide.sv
module blpt_decide (
   input  blpt_pkg::piece_state_type cur,
   input  blpt_pkg::window_type      win,
   output logic                      start,
   output blpt_pkg::piece_state_type nxt
);

   logic       contr_2;
   logic       contr_3;
   logic       lead_ok;
   logic       b0_letter;
   logic       b0_digit;
   logic       b0_space;
   logic       b1_letter;

   always_comb begin
      b0_letter = blpt_pkg::byte_is_alpha(win.b0);
      b0_digit  = blpt_pkg::byte_is_num(win.b0);
      b0_space  = blpt_pkg::byte_is_blank(win.b0);
      b1_letter = blpt_pkg::byte_is_alpha(win.b1);

      case (cur.kind)
         blpt_pkg::KIND_CONTR:  start = (cur.contr_left == 2'd0);
         blpt_pkg::KIND_LETTER: start = !b0_letter;
         blpt_pkg::KIND_SPACE:  start = !b0_space;
         blpt_pkg::KIND_OTHER:  start = b0_letter || b0_digit || b0_space;
         default:               start = 1'b1;
      endcase

      // 's 't 'm 'd and 're 've 'll, only with their bytes present
      contr_2 = (win.b0 == blpt_pkg::CHAR_APOSTROPHE) && (win.n != 2'd0) &&
                (win.b1 inside {blpt_pkg::CHAR_LOWER_S, blpt_pkg::CHAR_LOWER_T,
                                blpt_pkg::CHAR_LOWER_M, blpt_pkg::CHAR_LOWER_D});
      contr_3 = (win.b0 == blpt_pkg::CHAR_APOSTROPHE) && (win.n == 2'd2) &&
                (((win.b1 == blpt_pkg::CHAR_LOWER_R) && (win.b2 == blpt_pkg::CHAR_LOWER_E)) ||
                 ((win.b1 == blpt_pkg::CHAR_LOWER_V) && (win.b2 == blpt_pkg::CHAR_LOWER_E)) ||
                 ((win.b1 == blpt_pkg::CHAR_LOWER_L) && (win.b2 == blpt_pkg::CHAR_LOWER_L)));

      // one leading byte that is no letter, digit, CR or LF joins a following letter run
      lead_ok = !b0_letter && !b0_digit && (win.b0 != blpt_pkg::CHAR_CR) &&
                (win.b0 != blpt_pkg::CHAR_LF) && (win.n != 2'd0) && b1_letter;

      nxt = cur;
      if (start) begin
         nxt.contr_left = 2'd0;
         if (contr_2) begin
            nxt.kind       = blpt_pkg::KIND_CONTR;
            nxt.contr_left = 2'd1;
         end else if (contr_3) begin
            nxt.kind       = blpt_pkg::KIND_CONTR;
            nxt.contr_left = 2'd2;
         end else if (lead_ok || b0_letter) begin
            nxt.kind = blpt_pkg::KIND_LETTER;
         end else if (b0_digit) begin
            nxt.kind = blpt_pkg::KIND_DIGIT;
         end else if (b0_space) begin
            nxt.kind = blpt_pkg::KIND_SPACE;
         end else begin
            nxt.kind = blpt_pkg::KIND_OTHER;
         end
      end else if (cur.kind == blpt_pkg::KIND_CONTR) begin
         nxt.contr_left = cur.contr_left - 2'd1;
      end
   end

endmodule

FILE: rtl/byte_level_pretokenizer_core.sv
// channel  dir  handshake            payload
// req_if   in   valid/ready          text_byte[7:0], end_of_text
// rsp_if   out  valid/ready          piece_byte[7:0], starts_piece, ends_text, last_of_run
//
// one request per cycle unless flushing or stalled; a byte leaves two requests later
// an end-of-text request with k bytes held gives k+1 responses, sent by the flush
//   sequencer that walks the lookahead one byte a cycle while the output slot is free
// reset is synchronous, active high; clears lookahead count, piece state, valids
// a stalled response waits in the output register while the input register
//   still takes the next request
module byte_level_pretokenizer_core (
   input  logic       clock,
   input  logic       reset,
   blpt_req_if.sink   req_if,
   blpt_rsp_if.source rsp_if
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_eot_ff, in_eot_in;

   // two-byte lookahead, oldest in la0
   logic [7:0] la0_ff, la0_in;
   logic [7:0] la1_ff, la1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       flush_ff, flush_in;
   blpt_pkg::piece_state_type piece_ff, piece_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_start_ff, rsp_start_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       slot_free;
   logic       eot_mode;
   logic [1:0] total;
   logic [1:0] rem;
   logic       emit;
   logic       store;
   logic       consume;
   logic       accept;
   logic       dec_start;
   blpt_pkg::window_type      win;
   blpt_pkg::piece_state_type dec_piece;

   // output slot frees up when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign eot_mode  = flush_ff || in_eot_ff;

   // bytes in the virtual window: held bytes, then the pending request byte
   assign total = flush_ff ? cnt_ff : cnt_ff + 2'd1;
   assign rem   = total - 2'd1;

   always_comb begin
      win.b0 = (!flush_ff && (cnt_ff == 2'd0)) ? in_byte_ff : la0_ff;
      win.b1 = (!flush_ff && (cnt_ff == 2'd1)) ? in_byte_ff : la1_ff;
      win.b2 = in_byte_ff;
      win.n  = eot_mode ? rem : 2'd2;
   end

   blpt_decide u_decide (
      .cur   (piece_ff),
      .win   (win),
      .start (dec_start),
      .nxt   (dec_piece)
   );

   // a result goes out when flushing, at end of text, or with a full lookahead
   assign emit    = slot_free &&
                    (flush_ff || (in_valid_ff && (in_eot_ff || (cnt_ff == 2'd2))));
   // lookahead still filling: take the byte without a result
   assign store   = !flush_ff && in_valid_ff && !in_eot_ff && (cnt_ff != 2'd2);
   assign consume = store || (emit && !flush_ff);

   assign req_if.ready = !in_valid_ff || consume;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_eot_in    = in_eot_ff;
      la0_in       = la0_ff;
      la1_in       = la1_ff;
      cnt_in       = cnt_ff;
      flush_in     = flush_ff;
      piece_in     = piece_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_last_in  = rsp_last_ff;

      if (consume) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.text_byte;
         in_eot_in   = req_if.end_of_text;
      end

      if (store) begin
         if (cnt_ff == 2'd0) begin
            la0_in = in_byte_ff;
         end else begin
            la1_in = in_byte_ff;
         end
         cnt_in = cnt_ff + 2'd1;
      end

      if (emit) begin
         la0_in       = win.b1;
         la1_in       = win.b2;
         piece_in     = dec_piece;
         rsp_valid_in = 1'b1;
         rsp_byte_in  = win.b0;
         rsp_start_in = dec_start;
         rsp_end_in   = eot_mode && (rem == 2'd0);
         rsp_last_in  = !eot_mode || (rem == 2'd0);
         if (eot_mode) begin
            cnt_in   = rem;
            flush_in = (rem != 2'd0);
            // text done: back to the reset piece state
            if (rem == 2'd0) begin
               piece_in.kind       = blpt_pkg::KIND_NONE;
               piece_in.contr_left = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         cnt_ff              <= 2'd0;
         flush_ff            <= 1'b0;
         piece_ff.kind       <= blpt_pkg::KIND_NONE;
         piece_ff.contr_left <= 2'd0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         piece_ff     <= piece_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      in_eot_ff    <= in_eot_in;
      la0_ff       <= la0_in;
      la1_ff       <= la1_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.piece_byte   = rsp_byte_ff;
   assign rsp_if.starts_piece = rsp_start_ff;
   assign rsp_if.ends_text    = rsp_end_ff;
   assign rsp_if.last_of_run  = rsp_last_ff;

`ifndef SYNTHESIS
   // a flush always has held bytes left to send
   a_flush_has_bytes: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> (cnt_ff != 2'd0))
      else $error("flush with empty lookahead");

   // no new request is taken from the input register while flushing
   a_no_consume_in_flush: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> !consume)
      else $error("input consumed during flush");

   // a pending contraction count only lives inside a contraction piece
   a_contr_count_kind: assert property (@(posedge clock) disable iff (reset)
      (piece_ff.contr_left != 2'd0) |-> (piece_ff.kind == blpt_pkg::KIND_CONTR))
      else $error("contraction count outside contraction");

   // the final byte of a text leaves the core at its reset state
   a_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      (emit && eot_mode && (rem == 2'd0)) |=>
         ((cnt_ff == 2'd0) && !flush_ff && (piece_ff.kind == blpt_pkg::KIND_NONE)))
      else $error("state not cleared after end of text");

   // the lookahead never holds more than two bytes
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("lookahead count out of range");
`endif

endmodule

FILE: tb/tb_byte_level_pretokenizer_core.sv
module tb_byte_level_pretokenizer_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PERCENT    = 36;
   localparam int RANDOM_REQUESTS = 200;
   localparam int HOLD_CYCLES     = 40;    // long receiver hold-off that backs up the core
   localparam int HOLD_AFTER      = 30;    // responses seen before the hold-off starts
   localparam int CALM_FIRST      = 80;    // window of requests/responses with no idling
   localparam int CALM_LAST       = 140;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 1000;

   // one request as it sits in the sender's queue
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_req_type;

   // one response as the predictor expects it
   typedef struct packed {
      logic [7:0] piece_byte;
      logic       starts_piece;
      logic       ends_text;
      logic       last_of_run;
   } piece_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   blpt_req_if req_if ();
   blpt_rsp_if rsp_if ();

   byte_level_pretokenizer_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // piece predictor: own copy of lookahead, open piece and contraction
   // countdown, updated once per accepted request
   // ------------------------------------------------------------------
   logic [7:0]               held_bytes [2];
   int                       held_count;
   blpt_pkg::piece_kind_type open_kind;
   logic [1:0]               contr_remaining;

   piece_rsp_type expected_pieces [$];

   function automatic logic is_word_byte(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
             b >= blpt_pkg::HIGH_BYTE_FIRST;
   endfunction

   function automatic logic is_number_byte(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_blank_byte(input logic [7:0] b);
      return b == blpt_pkg::CHAR_SPACE || b == blpt_pkg::CHAR_TAB ||
             b == blpt_pkg::CHAR_LF || b == blpt_pkg::CHAR_CR;
   endfunction

   function automatic void clear_piece_state();
      held_bytes[0]   = 8'h00;
      held_bytes[1]   = 8'h00;
      held_count      = 0;
      open_kind       = blpt_pkg::KIND_NONE;
      contr_remaining = 2'd0;
   endfunction

   // classify the piece that opens at b0; avail tells how many of b1, b2 exist
   function automatic void open_new_piece(input logic [7:0] b0, input int avail,
                                          input logic [7:0] b1, input logic [7:0] b2);
      int clen;
      clen = 0;
      contr_remaining = 2'd0;
      if (b0 == blpt_pkg::CHAR_APOSTROPHE && avail >= 1) begin
         if (b1 == blpt_pkg::CHAR_LOWER_S || b1 == blpt_pkg::CHAR_LOWER_T ||
             b1 == blpt_pkg::CHAR_LOWER_M || b1 == blpt_pkg::CHAR_LOWER_D)
            clen = 2;
         else if (avail >= 2 &&
                  ((b1 == blpt_pkg::CHAR_LOWER_R && b2 == blpt_pkg::CHAR_LOWER_E) ||
                   (b1 == blpt_pkg::CHAR_LOWER_V && b2 == blpt_pkg::CHAR_LOWER_E) ||
                   (b1 == blpt_pkg::CHAR_LOWER_L && b2 == blpt_pkg::CHAR_LOWER_L)))
            clen = 3;
      end
      if (clen != 0) begin
         open_kind       = blpt_pkg::KIND_CONTR;
         contr_remaining = 2'(clen - 1);
      end else if (!is_word_byte(b0) && !is_number_byte(b0) && b0 != blpt_pkg::CHAR_CR &&
                   b0 != blpt_pkg::CHAR_LF && avail >= 1 && is_word_byte(b1)) begin
         open_kind = blpt_pkg::KIND_LETTER;
      end else if (is_word_byte(b0)) begin
         open_kind = blpt_pkg::KIND_LETTER;
      end else if (is_number_byte(b0)) begin
         open_kind = blpt_pkg::KIND_DIGIT;
      end else if (is_blank_byte(b0)) begin
         open_kind = blpt_pkg::KIND_SPACE;
      end else begin
         open_kind = blpt_pkg::KIND_OTHER;
      end
   endfunction

   function automatic logic piece_boundary(input logic [7:0] b0, input int avail,
                                           input logic [7:0] b1, input logic [7:0] b2);
      logic begins;
      case (open_kind)
         blpt_pkg::KIND_CONTR: begin
            begins = (contr_remaining == 2'd0);
            if (!begins)
               contr_remaining = contr_remaining - 2'd1;
         end
         blpt_pkg::KIND_LETTER: begins = !is_word_byte(b0);
         blpt_pkg::KIND_SPACE:  begins = !is_blank_byte(b0);
         blpt_pkg::KIND_OTHER:
            begins = is_word_byte(b0) || is_number_byte(b0) || is_blank_byte(b0);
         default:               begins = 1'b1;
      endcase
      if (begins)
         open_new_piece(b0, avail, b1, b2);
      return begins;
   endfunction

   task automatic absorb_text_byte(input logic [7:0] in_byte, input logic eot);
      logic [7:0]    window [3];
      int            total;
      int            avail;
      logic [7:0]    ctx1;
      logic [7:0]    ctx2;
      piece_rsp_type rsp;
      window[0] = held_bytes[0];
      window[1] = held_bytes[1];
      window[2] = 8'h00;
      window[held_count] = in_byte;
      total = held_count + 1;
      if (eot) begin
         // flush: every held byte plus this one, context cut at end of text
         for (int i = 0; i < total; i++) begin
            avail = total - 1 - i;
            ctx1  = 8'h00;
            ctx2  = 8'h00;
            if (avail >= 1)
               ctx1 = window[i + 1];
            if (avail >= 2)
               ctx2 = window[i + 2];
            rsp.piece_byte   = window[i];
            rsp.starts_piece = piece_boundary(window[i], avail, ctx1, ctx2);
            rsp.ends_text    = (i + 1 == total);
            rsp.last_of_run  = (i + 1 == total);
            expected_pieces.insert(expected_pieces.size(), rsp);
         end
         clear_piece_state();
      end else if (total < 3) begin
         held_bytes[0] = window[0];
         held_bytes[1] = window[1];
         held_count    = total;
      end else begin
         rsp.piece_byte   = window[0];
         rsp.starts_piece = piece_boundary(window[0], 2, window[1], window[2]);
         rsp.ends_text    = 1'b0;
         rsp.last_of_run  = 1'b1;
         expected_pieces.insert(expected_pieces.size(), rsp);
         held_bytes[0] = window[1];
         held_bytes[1] = window[2];
         held_count    = 2;
      end
   endtask

   // ------------------------------------------------------------------
   // text generation
   // ------------------------------------------------------------------
   text_req_type pending_requests [$];
   logic [7:0]   text_buf [$];
   int           texts_built;

   task automatic add_text_byte(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endtask

   // move the text under construction into the request queue, marking its end
   task automatic close_text();
      text_req_type r;
      for (int i = 0; i < text_buf.size(); i++) begin
         r.text_byte   = text_buf[i];
         r.end_of_text = (i == text_buf.size() - 1);
         pending_requests.insert(pending_requests.size(), r);
      end
      text_buf.delete();
      texts_built++;
   endtask

   task automatic append_string(input string s);
      for (int i = 0; i < s.len(); i++)
         add_text_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(2))
         0:       return 8'("a" + $urandom_range(25));
         1:       return 8'("A" + $urandom_range(25));
         default: return 8'($urandom_range(255, 128));
      endcase
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(3))
         0:       return blpt_pkg::CHAR_SPACE;
         1:       return blpt_pkg::CHAR_TAB;
         2:       return blpt_pkg::CHAR_CR;
         default: return blpt_pkg::CHAR_LF;
      endcase
   endfunction

   // punctuation and control bytes: neither letter, digit nor blank
   function automatic logic [7:0] pick_symbol();
      logic [7:0] b;
      b = 8'($urandom_range(127));
      while (is_word_byte(b) || is_number_byte(b) || is_blank_byte(b))
         b = 8'($urandom_range(127));
      return b;
   endfunction

   task automatic append_contraction();
      case ($urandom_range(6))
         0:       append_string("'s");
         1:       append_string("'t");
         2:       append_string("'re");
         3:       append_string("'ve");
         4:       append_string("'m");
         5:       append_string("'ll");
         default: append_string("'d");
      endcase
   endtask

   // mostly text built from word, contraction, number, blank and symbol
   // fragments; some texts are raw noise bytes
   task automatic build_random_text();
      int frags;
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(6, 1))
            add_text_byte(8'($urandom_range(255)));
      end else begin
         frags = ($urandom_range(9) == 0) ? $urandom_range(16, 8) : $urandom_range(6, 1);
         repeat (frags) begin
            case ($urandom_range(7))
               0, 1: repeat ($urandom_range(5, 1)) add_text_byte(pick_letter());
               2:    append_contraction();
               3:    repeat ($urandom_range(3, 1)) add_text_byte(8'("0" + $urandom_range(9)));
               4:    repeat ($urandom_range(3, 1)) add_text_byte(pick_blank());
               5:    repeat ($urandom_range(2, 1)) add_text_byte(pick_symbol());
               6:    add_text_byte(blpt_pkg::CHAR_APOSTROPHE);
               default: add_text_byte(8'($urandom_range(255)));
            endcase
         end
      end
      close_text();
   endtask

   // ------------------------------------------------------------------
   // handshake bookkeeping, shared between driver, receiver and monitor
   // ------------------------------------------------------------------
   logic req_taken;
   int   reqs_accepted;
   int   rsps_checked;
   int   pieces_started;
   int   mismatches;
   int   quiet_cycles;
   int   hold_left;
   logic hold_done;

   // request driver: new request only when the previous one has gone in
   always @(negedge clock) begin
      text_req_type next_req;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_requests.size() != 0 &&
             ((reqs_accepted >= CALM_FIRST && reqs_accepted < CALM_LAST) ||
              $urandom_range(99) >= IDLE_PERCENT)) begin
            next_req = pending_requests.pop_front();
            req_if.valid       <= 1'b1;
            req_if.text_byte   <= next_req.text_byte;
            req_if.end_of_text <= next_req.end_of_text;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response receiver: random stalls, one long hold-off, one calm stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!hold_done && rsps_checked >= HOLD_AFTER) begin
         hold_done    = 1'b1;
         hold_left    = HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (rsps_checked >= CALM_FIRST && rsps_checked < CALM_LAST) ||
                         ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // monitor: predict on accepted requests first, then check accepted responses
   always @(posedge clock) begin
      piece_rsp_type want;
      logic          rsp_taken;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_if.valid && req_if.ready;
         rsp_taken = rsp_if.valid && rsp_if.ready;
         if (req_taken) begin
            reqs_accepted++;
            absorb_text_byte(req_if.text_byte, req_if.end_of_text);
         end
         if (rsp_taken) begin
            rsps_checked++;
            if (rsp_if.starts_piece)
               pieces_started++;
            if (expected_pieces.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response byte=%02h starts=%b ends=%b last=%b",
                        $time, rsp_if.piece_byte, rsp_if.starts_piece,
                        rsp_if.ends_text, rsp_if.last_of_run);
            end else begin
               want = expected_pieces.pop_front();
               if (rsp_if.piece_byte !== want.piece_byte) begin
                  mismatches++;
                  $display("%0t: piece_byte expected %02h actual %02h",
                           $time, want.piece_byte, rsp_if.piece_byte);
               end
               if (rsp_if.starts_piece !== want.starts_piece) begin
                  mismatches++;
                  $display("%0t: starts_piece expected %b actual %b (byte %02h)",
                           $time, want.starts_piece, rsp_if.starts_piece, want.piece_byte);
               end
               if (rsp_if.ends_text !== want.ends_text) begin
                  mismatches++;
                  $display("%0t: ends_text expected %b actual %b (byte %02h)",
                           $time, want.ends_text, rsp_if.ends_text, want.piece_byte);
               end
               if (rsp_if.last_of_run !== want.last_of_run) begin
                  mismatches++;
                  $display("%0t: last_of_run expected %b actual %b (byte %02h)",
                           $time, want.last_of_run, rsp_if.last_of_run, want.piece_byte);
               end
            end
         end
         // watchdog: any handshake restarts the count
         if (req_taken || rsp_taken)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, expected_pieces.size());
            $display("byte_level_pretokenizer_core verification failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int random_reqs;
      int directed_reqs;
      req_if.valid       = 1'b0;
      req_if.text_byte   = 8'h00;
      req_if.end_of_text = 1'b0;
      rsp_if.ready       = 1'b0;
      req_taken          = 1'b0;
      reqs_accepted      = 0;
      rsps_checked       = 0;
      pieces_started     = 0;
      mismatches         = 0;
      quiet_cycles       = 0;
      hold_left          = 0;
      hold_done          = 1'b0;
      texts_built        = 0;
      clear_piece_state();

      // lone zero byte flushed from an empty lookahead
      add_text_byte(8'h00);
      close_text();
      // contractions flushed with two and with one byte held
      append_string("'ll");
      close_text();
      append_string("'m");
      close_text();
      // digit, then a contraction cut short by the end of text
      append_string("7'v");
      close_text();
      // blank run keeps its inner space, CR never leads a word, 's after a word
      append_string("  x's\015y");
      close_text();
      // apostrophe swallowed by a symbol run
      append_string("#'t");
      close_text();
      // high bytes count as letters around contractions
      append_string("\200're");
      close_text();
      append_string("'d\377");
      close_text();

      directed_reqs = pending_requests.size();
      random_reqs   = 0;
      while (random_reqs < RANDOM_REQUESTS) begin
         build_random_text();
         random_reqs = pending_requests.size() - directed_reqs;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all requests in, then every expected response out, then a short drain
      while (pending_requests.size() != 0 || req_if.valid)
         @(posedge clock);
      while (expected_pieces.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d texts, %0d requests, %0d responses, %0d piece starts",
               texts_built, reqs_accepted, rsps_checked, pieces_started);
      $display("receiver held off %0d cycles once, %0d field mismatches",
               HOLD_CYCLES, mismatches);
      if (mismatches == 0)
         $display("byte_level_pretokenizer_core verification clean");
      else
         $display("byte_level_pretokenizer_core verification failed");
      $finish;
   end

endmodule

FILE: byte_level_pretokenizer_core.f
rtl/blpt_pkg.sv
rtl/blpt_if.sv
rtl/blpt_decide.sv
rtl/byte_level_pretokenizer_core.sv
tb/tb_byte_level_pretokenizer_core.sv
